@@ sv/lzssd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lzssd_pkg;

    // Window geometry: 4096 bytes, 12-bit pointers.
    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);

    // Number of header bytes skipped before the length field.
    localparam int HEADER_SKIP = 5;

    // Write pointer value at the start of every stream.
    localparam logic [WIN_AW-1:0] WPTR_INIT = WIN_AW'(12'hfee);

    // Reset value of the length limit register.
    localparam logic [23:0] LIMIT_RESET = 24'd1000000;

    // Stream widths.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;
    localparam int CFG_W      = 24;

    // Bit positions inside the output tdata.
    localparam int OD_BYTE_LSB   = 0;
    localparam int OD_STATUS_LSB = 8;
    localparam int OD_TOTAL_LSB  = 10;
    localparam int OD_TOTAL_MSB  = 33;

    // End-of-stream status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

endpackage

`default_nettype wire

@@ sv/lzss_stream_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// LZSS stream decoder with a 4096-byte window. Compressed bytes enter one item at a time on
// the s_ side (s_tlast marks the final byte of a stream); decoded bytes and one end-of-stream
// status item leave on the m_ side (m_tuser high marks the status item, m_tlast the final
// result item of an input). A header byte, length byte, flag byte or first reference byte
// needs no further step. A literal is registered and then emitted. The second reference byte
// starts a copy of at most 18 bytes, with a read step and then a write step for each copied
// byte: the window memory has a registered read port, and a copy may read the byte it just
// wrote. The final byte of a stream adds a step for the status item. Output back-pressure
// holds any step that emits, and no input byte is taken until the block is idle again. The
// window needs no clearing pass: writes always run forward from 0xfee, so a fill count tells
// which entries were written in the current stream, and any other entry reads as zero.
// length_limit may be written while no stream byte is in flight.
module lzss_stream_decoder (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration: length_limit
    input  wire logic                               cfg_wr_en,
    input  wire logic [lzssd_pkg::CFG_W-1:0]        cfg_wr_data,
    // Input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [lzssd_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                               s_tlast,   // last_byte
    // Output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lzssd_pkg::OUT_DATA_W-1:0]        m_tdata,   // [7:0] out_byte, [9:8] status,
                                                               // [33:10] total_count, rest 0
    output logic [lzssd_pkg::OUT_USER_W-1:0]        m_tuser,   // [0] is_status
    output logic                                    m_tlast    // run_last
);

    import lzssd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EMIT  = 5'b00010,
        S_REFRD = 5'b00100,
        S_REFWR = 5'b01000,
        S_STAT  = 5'b10000
    } state_t;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_LENGTH = 6'b000010,
        PH_ITEM   = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_REFHI  = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    localparam phase_t      PH_START = (HEADER_SKIP == 0) ? PH_LENGTH : PH_HEADER;
    localparam logic [3:0]  HDR_SKIP = 4'(HEADER_SKIP);
    localparam logic [WIN_AW:0] FILL_FULL = (WIN_AW+1)'(WINDOW_SIZE);

    // Control and stream state
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [3:0]          hdr_pos_reg, hdr_pos_next;
    logic [31:0]         decl_len_reg, decl_len_next;
    logic [23:0]         remaining_reg, remaining_next;
    logic [23:0]         produced_reg, produced_next;
    logic                stopped_reg, stopped_next;
    logic [15:0]         flag_reg, flag_next;
    logic [7:0]          ref_low_reg, ref_low_next;
    logic [WIN_AW-1:0]   wptr_reg, wptr_next;
    logic [WIN_AW:0]     fill_reg, fill_next;
    logic [WIN_AW-1:0]   src_reg, src_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [7:0]          lit_reg, lit_next;
    logic                last_reg, last_next;
    status_t             stat_reg, stat_next;
    logic                rd_hit_reg, rd_hit_next;
    logic [23:0]         limit_reg, limit_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_byte_reg, m_byte_next;
    logic                m_stat_item_reg, m_stat_item_next;
    logic                m_last_reg, m_last_next;
    status_t             m_status_reg, m_status_next;
    logic [23:0]         m_total_reg, m_total_next;

    // Window memory
    logic [7:0]          win_mem [0:WINDOW_SIZE-1];
    logic [7:0]          win_q;
    logic                win_we;
    logic                win_rd_en;
    logic [7:0]          win_wdata;

    // Scratch values of the decode step
    logic                out_free;
    logic                emit;
    logic [7:0]          emit_byte;
    logic                emit_last;
    logic [3:0]          pos_inc;
    logic [15:0]         flag_shift;
    logic                is_flag;
    logic [4:0]          cnt_raw;
    logic [WIN_AW-1:0]   rel_src;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign rel_src  = src_reg - WPTR_INIT;

    // Next-state logic of the sequencer and the decode state
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        hdr_pos_next   = hdr_pos_reg;
        decl_len_next  = decl_len_reg;
        remaining_next = remaining_reg;
        produced_next  = produced_reg;
        stopped_next   = stopped_reg;
        flag_next      = flag_reg;
        ref_low_next   = ref_low_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        lit_next       = lit_reg;
        last_next      = last_reg;
        stat_next      = stat_reg;
        rd_hit_next    = rd_hit_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;

        m_valid_next     = m_valid_reg && !m_tready;
        m_byte_next      = m_byte_reg;
        m_stat_item_next = m_stat_item_reg;
        m_last_next      = m_last_reg;
        m_status_next    = m_status_reg;
        m_total_next     = m_total_reg;

        win_rd_en  = 1'b0;
        emit       = 1'b0;
        emit_byte  = 8'd0;
        emit_last  = 1'b0;
        pos_inc    = 4'd0;
        flag_shift = 16'd0;
        is_flag    = 1'b0;
        cnt_raw    = 5'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? S_STAT : S_IDLE;
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            pos_inc = (hdr_pos_reg < HDR_SKIP) ? hdr_pos_reg + 4'd1 : hdr_pos_reg;
                            if (pos_inc >= HDR_SKIP)
                            begin
                                phase_next   = PH_LENGTH;
                                hdr_pos_next = 4'd0;
                            end
                            else
                            begin
                                hdr_pos_next = pos_inc;
                            end
                        end
                        PH_LENGTH:
                        begin
                            decl_len_next = decl_len_reg
                                | ({24'd0, s_tdata} << {hdr_pos_reg[1:0], 3'b000});
                            hdr_pos_next  = hdr_pos_reg + 4'd1;
                            if (hdr_pos_reg >= 4'd3)
                            begin
                                hdr_pos_next = 4'd0;
                                if (decl_len_next > {8'd0, limit_reg})
                                begin
                                    stopped_next = 1'b1;
                                    phase_next   = PH_ERROR;
                                end
                                else
                                begin
                                    remaining_next = decl_len_next[23:0];
                                    phase_next     = PH_ITEM;
                                end
                            end
                        end
                        PH_ITEM, PH_BODY:
                        begin
                            if (remaining_reg != 24'd0)
                            begin
                                if (phase_reg == PH_ITEM)
                                begin
                                    flag_shift = {1'b0, flag_reg[15:1]};
                                    flag_next  = flag_shift;
                                    if (!flag_shift[8])
                                    begin
                                        flag_next  = {8'hff, s_tdata};
                                        phase_next = PH_BODY;
                                        is_flag    = 1'b1;
                                    end
                                end
                                if (!is_flag)
                                begin
                                    if (flag_next[0])
                                    begin
                                        // Literal byte
                                        lit_next   = s_tdata;
                                        phase_next = PH_ITEM;
                                        state_next = S_EMIT;
                                    end
                                    else
                                    begin
                                        ref_low_next = s_tdata;
                                        phase_next   = PH_REFHI;
                                    end
                                end
                            end
                        end
                        PH_REFHI:
                        begin
                            // Second reference byte: start the window copy.
                            src_next = {s_tdata[7:4], ref_low_reg};
                            cnt_raw  = {1'b0, s_tdata[3:0]} + 5'd3;
                            cnt_next = ({19'd0, cnt_raw} > remaining_reg) ?
                                       remaining_reg[4:0] : cnt_raw;
                            phase_next = PH_ITEM;
                            state_next = S_REFRD;
                        end
                        PH_ERROR:
                        begin
                            phase_next = PH_ERROR;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    // Status of the stream, taken after this byte.
                    if (phase_next == PH_HEADER || phase_next == PH_LENGTH)
                    begin
                        stat_next = ST_SHORT;
                    end
                    else if (stopped_next)
                    begin
                        stat_next = ST_OVER;
                    end
                    else
                    begin
                        stat_next = ST_OK;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = lit_reg;
                    emit_last  = !last_reg;
                    state_next = last_reg ? S_STAT : S_IDLE;
                end
            end
            S_REFRD:
            begin
                // Read the source byte; entries not yet written in this stream read as zero.
                win_rd_en   = 1'b1;
                rd_hit_next = ({1'b0, rel_src} < fill_reg);
                state_next  = S_REFWR;
            end
            S_REFWR:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_byte = rd_hit_reg ? win_q : 8'd0;
                    emit_last = (cnt_reg == 5'd1) && !last_reg;
                    src_next  = src_reg + WIN_AW'(1);
                    cnt_next  = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_next = last_reg ? S_STAT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REFRD;
                    end
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    m_valid_next     = 1'b1;
                    m_byte_next      = 8'd0;
                    m_stat_item_next = 1'b1;
                    m_last_next      = 1'b1;
                    m_status_next    = stat_reg;
                    m_total_next     = (stat_reg == ST_OK) ? produced_reg : 24'd0;

                    // Return all stream state to its start values.
                    phase_next     = PH_START;
                    hdr_pos_next   = 4'd0;
                    decl_len_next  = 32'd0;
                    remaining_next = 24'd0;
                    produced_next  = 24'd0;
                    stopped_next   = 1'b0;
                    flag_next      = 16'd0;
                    ref_low_next   = 8'd0;
                    wptr_next      = WPTR_INIT;
                    fill_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // One decoded byte: into the window and into the output register.
        if (emit)
        begin
            wptr_next        = wptr_reg + WIN_AW'(1);
            fill_next        = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + (WIN_AW+1)'(1);
            remaining_next   = remaining_reg - 24'd1;
            produced_next    = produced_reg + 24'd1;
            m_valid_next     = 1'b1;
            m_byte_next      = emit_byte;
            m_stat_item_next = 1'b0;
            m_last_next      = emit_last;
            m_status_next    = ST_OK;
            m_total_next     = 24'd0;
        end
    end

    assign win_we    = emit;
    assign win_wdata = emit_byte;

    // Window memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[wptr_reg] <= win_wdata;
        end
        if (win_rd_en)
        begin
            win_q <= win_mem[src_reg];
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_START;
            hdr_pos_reg     <= 4'd0;
            decl_len_reg    <= 32'd0;
            remaining_reg   <= 24'd0;
            produced_reg    <= 24'd0;
            stopped_reg     <= 1'b0;
            flag_reg        <= 16'd0;
            ref_low_reg     <= 8'd0;
            wptr_reg        <= WPTR_INIT;
            fill_reg        <= '0;
            src_reg         <= '0;
            cnt_reg         <= 5'd0;
            lit_reg         <= 8'd0;
            last_reg        <= 1'b0;
            stat_reg        <= ST_OK;
            rd_hit_reg      <= 1'b0;
            limit_reg       <= LIMIT_RESET;
            m_valid_reg     <= 1'b0;
            m_byte_reg      <= 8'd0;
            m_stat_item_reg <= 1'b0;
            m_last_reg      <= 1'b0;
            m_status_reg    <= ST_OK;
            m_total_reg     <= 24'd0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            hdr_pos_reg     <= hdr_pos_next;
            decl_len_reg    <= decl_len_next;
            remaining_reg   <= remaining_next;
            produced_reg    <= produced_next;
            stopped_reg     <= stopped_next;
            flag_reg        <= flag_next;
            ref_low_reg     <= ref_low_next;
            wptr_reg        <= wptr_next;
            fill_reg        <= fill_next;
            src_reg         <= src_next;
            cnt_reg         <= cnt_next;
            lit_reg         <= lit_next;
            last_reg        <= last_next;
            stat_reg        <= stat_next;
            rd_hit_reg      <= rd_hit_next;
            limit_reg       <= limit_next;
            m_valid_reg     <= m_valid_next;
            m_byte_reg      <= m_byte_next;
            m_stat_item_reg <= m_stat_item_next;
            m_last_reg      <= m_last_next;
            m_status_reg    <= m_status_next;
            m_total_reg     <= m_total_next;
        end
    end

    // Output ports
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OD_TOTAL_MSB - 1)'(0), m_total_reg, m_status_reg, m_byte_reg};
    assign m_tuser  = m_stat_item_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ sv/lzssd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lzssd_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic                               s_tlast,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [lzssd_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire logic [lzssd_pkg::OUT_USER_W-1:0]   m_tuser,
    input  wire logic                               m_tlast
);

    import lzssd_pkg::*;

    // A stalled output item holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    // The status item always closes the results of its input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("status item without tlast");

    // Data items carry no status and no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[OUT_DATA_W-1:OD_STATUS_LSB] == '0)
        else $error("data item with status bits set");

    // A failed stream reports a zero count, and the status code is a known one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tdata[OD_STATUS_LSB +: 2] != ST_OK
        |-> m_tdata[OD_TOTAL_MSB:OD_TOTAL_LSB] == '0
            && m_tdata[OD_STATUS_LSB +: 2] != 2'd3)
        else $error("bad status item");

    // The final byte of a stream always causes a status item, so the input stalls after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready right after the final byte");

endmodule

bind lzss_stream_decoder lzssd_checker u_lzssd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
